// ===== rtl/telnet_line_discipline_core_defines.svh =====
// Assertion macros for the telnet line discipline core.
`ifndef TELNET_LINE_DISCIPLINE_CORE_DEFINES_SVH
`define TELNET_LINE_DISCIPLINE_CORE_DEFINES_SVH

// cond implies prop in the same cycle
`define TLD_ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// cond implies prop in the next cycle
`define TLD_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// cond never holds
`define TLD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/tld_pkg.sv =====
// Shared types, constants and tables of the telnet line discipline core.
package tld_pkg;

    localparam int unsigned LINE_MAX   = 4096;
    localparam int          LEN_W      = 13;
    localparam int          STEP_W     = 4;
    localparam int          FIFO_DEPTH = 4;
    localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int          FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] B_IAC   = 8'd255;
    localparam logic [7:0] B_DO    = 8'd253;
    localparam logic [7:0] B_WILL  = 8'd251;
    localparam logic [7:0] B_SB    = 8'd250;
    localparam logic [7:0] B_SE    = 8'd240;
    localparam logic [7:0] B_DEL   = 8'h7f;
    localparam logic [7:0] B_NUL   = 8'd0;
    localparam logic [7:0] B_BS    = 8'd8;
    localparam logic [7:0] B_LF    = 8'd10;
    localparam logic [7:0] B_CR    = 8'd13;
    localparam logic [7:0] B_SPACE = 8'd32;
    localparam logic [7:0] B_STAR  = 8'h2a;
    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;

    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        JOB_NEG,
        JOB_PROMPT,
        JOB_ERASE,
        JOB_STORE,
        JOB_LINE
    } job_op_t;

    typedef enum logic [1:0] {
        KIND_SEND  = 2'd0,
        KIND_STORE = 2'd1,
        KIND_ERASE = 2'd2,
        KIND_LINE  = 2'd3
    } kind_t;

    typedef struct packed {
        job_op_t    op;
        logic       has_erase;
        logic [7:0] value;
        logic [7:0] echo;
        len_t       len;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    function automatic logic [7:0] neg_byte(input step_t idx);
        logic [7:0] b;
        case (idx)
            4'd0, 4'd3, 4'd6: b = B_IAC;
            4'd1:             b = B_DO;
            4'd4, 4'd7:       b = B_WILL;
            4'd2, 4'd5:       b = OPT_ECHO;
            4'd8:             b = OPT_SGA;
            default:          b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] prompt_byte(input step_t idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = "l";
            4'd1:    b = "o";
            4'd2:    b = "g";
            4'd3:    b = "i";
            4'd4:    b = "n";
            4'd5:    b = ":";
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/tld_front.sv =====
// Front end: telnet command parser, line state and job issue.
module tld_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_tuser,
    input  logic [7:0]        s_tdata,
    input  tld_pkg::fifo_stat_t fifo_stat,
    output logic              push,
    output tld_pkg::job_t     push_job
);
    import tld_pkg::*;

    typedef enum logic [2:0] {
        PH_NORMAL,
        PH_VERB,
        PH_OPTION,
        PH_SB_BODY,
        PH_SB_IAC
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   cr_reg, cr_next;
    logic   pend_reg, pend_next;
    len_t   count_reg, count_next;
    logic   mask_reg;
    logic   accept;
    logic [7:0] ch;

    assign s_tready = !fifo_stat.full;
    assign accept   = s_tvalid && !fifo_stat.full;
    assign ch       = s_tdata;

    always_comb
    begin
        phase_next = phase_reg;
        cr_next    = cr_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        push       = 1'b0;
        push_job   = '0;
        if (accept)
        begin
            if (s_tuser)
            begin
                phase_next   = PH_NORMAL;
                cr_next      = 1'b0;
                pend_next    = 1'b1;
                count_next   = '0;
                push         = 1'b1;
                push_job.op  = JOB_NEG;
                push_job.len = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_VERB:
                    begin
                        phase_next = (ch == B_SB) ? PH_SB_BODY : PH_OPTION;
                    end
                    PH_OPTION:
                    begin
                        phase_next = PH_NORMAL;
                        if (pend_reg)
                        begin
                            pend_next    = 1'b0;
                            push         = 1'b1;
                            push_job.op  = JOB_PROMPT;
                            push_job.len = count_reg;
                        end
                    end
                    PH_SB_BODY:
                    begin
                        if (ch == B_IAC)
                            phase_next = PH_SB_IAC;
                    end
                    PH_SB_IAC:
                    begin
                        if (ch == B_SE)
                        begin
                            phase_next = PH_NORMAL;
                            if (pend_reg)
                            begin
                                pend_next    = 1'b0;
                                push         = 1'b1;
                                push_job.op  = JOB_PROMPT;
                                push_job.len = count_reg;
                            end
                        end
                        else if (ch != B_IAC)
                            phase_next = PH_SB_BODY;
                    end
                    default:
                    begin
                        // plain text
                        phase_next = PH_NORMAL;
                        if (ch == B_IAC)
                        begin
                            cr_next    = 1'b0;
                            phase_next = PH_VERB;
                        end
                        else
                        begin
                            cr_next = (ch == B_CR);
                            if (ch == B_NUL)
                            begin
                                if (cr_reg)
                                begin
                                    push         = 1'b1;
                                    push_job.op  = JOB_LINE;
                                    push_job.len = count_reg;
                                    count_next   = '0;
                                end
                            end
                            else if (ch == B_BS || ch == B_DEL)
                            begin
                                push               = 1'b1;
                                push_job.op        = JOB_ERASE;
                                push_job.has_erase = (count_reg != '0);
                                if (count_reg != '0)
                                    count_next = count_reg - len_t'(1);
                                push_job.len = count_next;
                            end
                            else if (ch == B_LF)
                            begin
                                push         = 1'b1;
                                push_job.op  = JOB_LINE;
                                push_job.len = count_reg;
                                count_next   = '0;
                            end
                            else if (ch != B_CR && count_reg < len_t'(LINE_MAX))
                            begin
                                count_next     = count_reg + len_t'(1);
                                push           = 1'b1;
                                push_job.op    = JOB_STORE;
                                push_job.value = ch;
                                push_job.echo  = mask_reg ? B_STAR : ch;
                                push_job.len   = count_next;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NORMAL;
            cr_reg    <= 1'b0;
            pend_reg  <= 1'b0;
            count_reg <= '0;
            mask_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            if (cfg_wr_en)
                mask_reg <= cfg_wr_data;
        end
    end

endmodule

// ===== rtl/tld_fifo.sv =====
// Job queue between the front end and the result sequencer.
module tld_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tld_pkg::job_t       push_job,
    input  logic                pop,
    output tld_pkg::job_t       head_job,
    output tld_pkg::fifo_stat_t fifo_stat
);
    import tld_pkg::*;

    job_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wptr_reg;
    logic [FIFO_AW-1:0] rptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign fifo_stat.empty = (count_reg == '0);
    assign fifo_stat.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign do_push  = push && !fifo_stat.full;
    assign do_pop   = pop && !fifo_stat.empty;
    assign head_job = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= wptr_reg + FIFO_AW'(1);
            if (do_pop)
                rptr_reg <= rptr_reg + FIFO_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + FIFO_CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - FIFO_CW'(1);
        end
    end

endmodule

// ===== rtl/tld_back.sv =====
// Back end: expands jobs into result words, one per cycle unless m_tready stalls, behind an output register.
module tld_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tld_pkg::fifo_stat_t fifo_stat,
    input  tld_pkg::job_t       head_job,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic [1:0]          m_tuser,
    output logic                m_tlast
);
    import tld_pkg::*;

    job_t       cur_reg;
    logic       cur_valid_reg;
    step_t      step_reg;
    logic       out_valid_reg;
    kind_t      out_kind_reg;
    logic [7:0] out_value_reg;
    len_t       out_len_reg;
    logic       out_last_reg;

    kind_t      res_kind;
    logic [7:0] res_value;
    len_t       res_len;
    logic       res_last;
    logic       out_free;
    logic       fire;

    always_comb
    begin
        res_kind  = KIND_SEND;
        res_value = 8'd0;
        res_len   = cur_reg.len;
        res_last  = 1'b0;
        case (cur_reg.op)
            JOB_NEG:
            begin
                res_value = neg_byte(step_reg);
                res_last  = (step_reg == step_t'(8));
            end
            JOB_PROMPT:
            begin
                res_value = prompt_byte(step_reg);
                res_last  = (step_reg == step_t'(5));
            end
            JOB_ERASE:
            begin
                if (step_reg == '0)
                    res_kind = KIND_ERASE;
                else if (step_reg == step_t'(2))
                    res_value = B_SPACE;
                else
                    res_value = B_BS;
                res_last = (step_reg == step_t'(3));
            end
            JOB_STORE:
            begin
                if (step_reg == '0)
                begin
                    res_kind  = KIND_STORE;
                    res_value = cur_reg.value;
                end
                else
                    res_value = cur_reg.echo;
                res_last = (step_reg == step_t'(1));
            end
            JOB_LINE:
            begin
                if (step_reg == '0)
                    res_value = B_LF;
                else
                begin
                    res_kind = KIND_LINE;
                    res_len  = '0;
                end
                res_last = (step_reg == step_t'(1));
            end
            default:
            begin
                res_last = 1'b1;
            end
        endcase
    end

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = cur_valid_reg && out_free;
    assign pop      = !fifo_stat.empty && (!cur_valid_reg || (fire && res_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                step_reg      <= (head_job.op == JOB_ERASE && !head_job.has_erase)
                                 ? step_t'(1) : '0;
            end
            else if (fire && res_last)
                cur_valid_reg <= 1'b0;
            else if (fire)
                step_reg <= step_reg + step_t'(1);

            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= head_job;
        if (fire)
        begin
            out_kind_reg  <= res_kind;
            out_value_reg <= res_value;
            out_len_reg   <= res_len;
            out_last_reg  <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_len_reg, out_value_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/telnet_line_discipline_core.sv =====
// Top level of the telnet line discipline core.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tuser: opcode; tdata: data_byte
//  m_*      out  m_tvalid/m_tready    tuser: kind; tdata: value, line_length; tlast: last
//  cfg_*    in   cfg_wr_en            cfg_wr_data: mask_echo
//
// The front end takes one byte per cycle while the 4-entry job queue has room.
// The back end sends one result word per cycle unless stalled; a byte yields
// 2 words for a stored character or a line end, 3 or 4 for an erase,
// 6 for the prompt, 9 for a session start. A stall on m_tready holds the output
// register and fills the queue. Reset is immediate, no clearing pass.
`include "telnet_line_discipline_core_defines.svh"

module telnet_line_discipline_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,  // mask_echo
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic        s_tuser,      // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,      // [7:0] value, [20:8] line_length, [23:21] zero
    output logic [1:0]  m_tuser,      // [1:0] kind
    output logic        m_tlast       // last word of this byte
);
    import tld_pkg::*;

    fifo_stat_t fifo_stat;
    logic       push;
    job_t       push_job;
    logic       pop;
    job_t       head_job;

    tld_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .fifo_stat  (fifo_stat),
        .push       (push),
        .push_job   (push_job)
    );

    tld_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .fifo_stat(fifo_stat)
    );

    tld_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .fifo_stat(fifo_stat),
        .head_job (head_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `TLD_ASSERT_IMPLY(a_line_is_last, m_tvalid && m_tuser == KIND_LINE, m_tlast && m_tdata[20:8] == '0, "line complete word not final or nonzero length")
    `TLD_ASSERT_NEXT(a_session_queued, s_tvalid && s_tready && s_tuser, !fifo_stat.empty, "session start produced no job")
    `TLD_ASSERT_NEVER(a_fifo_stat, fifo_stat.empty && fifo_stat.full, "job queue both empty and full")
    `TLD_ASSERT_IMPLY(a_len_range, m_tvalid, m_tdata[20:8] <= 13'(LINE_MAX), "line length beyond capacity")

endmodule

// ===== tb/tb_telnet_line_discipline_core.sv =====
// Testbench for telnet_line_discipline_core: random and directed stream traffic checked by a scoreboard.
module tb_telnet_line_discipline_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tld_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [7:0] NEG_BYTES [9] = '{B_IAC, B_DO, OPT_ECHO, B_IAC, B_WILL, OPT_ECHO,
                                             B_IAC, B_WILL, OPT_SGA};
    localparam logic [7:0] LOGIN_TEXT [6] = '{"l", "o", "g", "i", "n", ":"};
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DONT = 8'd254;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_VERB,
        PH_OPTION,
        PH_SUB,
        PH_SUB_IAC
    } phase_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        len_t       len;
        logic       last;
    } result_word_t;

    class line_discipline_scoreboard;
        result_word_t expected_words[$];
        phase_t       phase;
        bit           cr_seen;
        bit           prompt_pending;
        bit           mask_echo;
        int unsigned  line_len;
        int           errors;

        function new();
            phase = PH_TEXT;
            cr_seen = 0;
            prompt_pending = 0;
            mask_echo = 0;
            line_len = 0;
            errors = 0;
        endfunction

        function void add(kind_t k, logic [7:0] v);
            result_word_t w;
            w.kind = k;
            w.value = v;
            w.len = len_t'(line_len);
            w.last = 1'b0;
            expected_words.push_back(w);
        endfunction

        function void finish_command();
            phase = PH_TEXT;
            if (prompt_pending)
            begin
                prompt_pending = 0;
                for (int i = 0; i < 6; i++)
                    add(KIND_SEND, LOGIN_TEXT[i]);
            end
        endfunction

        function void end_line();
            add(KIND_SEND, B_LF);
            line_len = 0;
            add(KIND_LINE, 8'd0);
        endfunction

        function void note_input(logic op, logic [7:0] ch);
            int base;
            result_word_t w;
            base = expected_words.size();
            if (op)
            begin
                phase = PH_TEXT;
                cr_seen = 0;
                prompt_pending = 1;
                line_len = 0;
                for (int i = 0; i < 9; i++)
                    add(KIND_SEND, NEG_BYTES[i]);
            end
            else
            begin
                case (phase)
                    PH_VERB: phase = (ch == B_SB) ? PH_SUB : PH_OPTION;
                    PH_OPTION: finish_command();
                    PH_SUB:
                        if (ch == B_IAC)
                            phase = PH_SUB_IAC;
                    PH_SUB_IAC:
                        if (ch == B_SE)
                            finish_command();
                        else if (ch != B_IAC)
                            phase = PH_SUB;
                    default:
                    begin
                        if (ch == B_IAC)
                        begin
                            cr_seen = 0;
                            phase = PH_VERB;
                        end
                        else
                        begin
                            if (ch == B_NUL)
                            begin
                                if (cr_seen)
                                    end_line();
                            end
                            else if (ch == B_BS || ch == B_DEL)
                            begin
                                if (line_len > 0)
                                begin
                                    line_len--;
                                    add(KIND_ERASE, 8'd0);
                                end
                                add(KIND_SEND, B_BS);
                                add(KIND_SEND, B_SPACE);
                                add(KIND_SEND, B_BS);
                            end
                            else if (ch == B_LF)
                                end_line();
                            else if (ch != B_CR && line_len < LINE_MAX)
                            begin
                                line_len++;
                                add(KIND_STORE, ch);
                                add(KIND_SEND, mask_echo ? B_STAR : ch);
                            end
                            cr_seen = (ch == B_CR);
                        end
                    end
                endcase
            end
            if (expected_words.size() > base)
            begin
                w = expected_words[expected_words.size() - 1];
                w.last = 1'b1;
                expected_words[expected_words.size() - 1] = w;
            end
        endfunction

        task report(string msg);
            $display("%0t ns: error: %s", $time, msg);
            errors++;
        endtask

        task check_word(kind_t k, logic [7:0] v, len_t len, logic last);
            result_word_t w;
            if (expected_words.size() == 0)
                report($sformatf("unexpected word kind=%0d value=%0d len=%0d last=%0b",
                                 k, v, len, last));
            else
            begin
                w = expected_words.pop_front();
                if (k !== w.kind)
                    report($sformatf("kind %0d, want %0d", k, w.kind));
                if (v !== w.value)
                    report($sformatf("value %0d, want %0d", v, w.value));
                if (len !== w.len)
                    report($sformatf("line_length %0d, want %0d", len, w.len));
                if (last !== w.last)
                    report($sformatf("last %0b, want %0b", last, w.last));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    line_discipline_scoreboard sb;
    int src_idle;
    int sink_idle;
    int sent_count;
    int cycle_count;

    telnet_line_discipline_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(kind_t'(m_tuser), m_tdata[7:0], m_tdata[20:8], m_tlast);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("telnet_line_discipline_core: mismatch");
            $finish;
        end
    end

    task send_byte(logic op, logic [7:0] b);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(op, b);
        sent_count++;
    endtask

    task settle(int cycles);
        s_tvalid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (cycles) @(posedge clk);
    endtask

    task set_echo_mask(bit m);
        settle(12);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.mask_echo = m;
    endtask

    task random_traffic(int n);
        int stop_at;
        int r;
        int body;
        stop_at = sent_count + n;
        while (sent_count < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_byte(1'b0, 8'($urandom_range(32, 126)));
            else if (r < 55)
                send_byte(1'b0, $urandom_range(1) ? B_BS : B_DEL);
            else if (r < 62)
            begin
                send_byte(1'b0, B_CR);
                send_byte(1'b0, B_NUL);
            end
            else if (r < 68)
                send_byte(1'b0, B_LF);
            else if (r < 70)
            begin
                send_byte(1'b0, B_CR);
                send_byte(1'b0, 8'($urandom_range(255)));
            end
            else if (r < 78)
            begin
                send_byte(1'b0, B_IAC);
                case ($urandom_range(4))
                    0: send_byte(1'b0, B_DO);
                    1: send_byte(1'b0, B_WILL);
                    2: send_byte(1'b0, B_WONT);
                    3: send_byte(1'b0, B_DONT);
                    default: send_byte(1'b0, B_IAC);
                endcase
                send_byte(1'b0, 8'($urandom_range(255)));
            end
            else if (r < 84)
            begin
                send_byte(1'b0, B_IAC);
                send_byte(1'b0, B_SB);
                body = $urandom_range(6);
                repeat (body)
                    send_byte(1'b0, $urandom_range(3) == 0 ? B_IAC : 8'($urandom_range(255)));
                send_byte(1'b0, B_IAC);
                send_byte(1'b0, B_SE);
            end
            else if (r < 88)
                send_byte(1'b1, 8'($urandom_range(255)));
            else if (r < 93)
                send_byte(1'b0, B_NUL);
            else
                send_byte(1'($urandom_range(9) == 0), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        src_idle = 16;
        sink_idle = 58;
        sent_count = 0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: before session, negotiation, prompt, editing, line ends, commands
        send_byte(1'b0, "x");
        send_byte(1'b1, 8'ha5);
        send_byte(1'b0, B_IAC);
        send_byte(1'b0, B_DO);
        send_byte(1'b0, OPT_ECHO);
        send_byte(1'b0, B_IAC);
        send_byte(1'b0, B_IAC);
        send_byte(1'b0, 8'h07);
        send_byte(1'b0, 8'h01);
        send_byte(1'b0, 8'hfe);
        send_byte(1'b0, B_BS);
        send_byte(1'b0, B_DEL);
        send_byte(1'b0, B_DEL);
        send_byte(1'b0, B_NUL);
        send_byte(1'b0, "a");
        send_byte(1'b0, B_CR);
        send_byte(1'b0, B_NUL);
        send_byte(1'b0, B_CR);
        send_byte(1'b0, "b");
        send_byte(1'b0, B_LF);
        send_byte(1'b0, B_IAC);
        send_byte(1'b0, B_SB);
        send_byte(1'b0, B_IAC);
        send_byte(1'b0, 8'h18);
        send_byte(1'b0, B_IAC);
        send_byte(1'b0, B_IAC);
        send_byte(1'b0, B_SE);

        set_echo_mask(1'b1);
        random_traffic(114);

        src_idle = 58;
        sink_idle = 16;
        set_echo_mask(1'b0);
        random_traffic(114);

        src_idle = 0;
        sink_idle = 0;
        set_echo_mask(1'b1);
        random_traffic(114);

        settle(SETTLE_CYCLES);
        if (sb.errors == 0)
            $display("telnet_line_discipline_core: match");
        else
            $display("telnet_line_discipline_core: mismatch");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tld_pkg.sv
rtl/tld_front.sv
rtl/tld_fifo.sv
rtl/tld_back.sv
rtl/telnet_line_discipline_core.sv
tb/tb_telnet_line_discipline_core.sv
